// File: design/mld_pkg.sv
// mld_pkg: constants, codes, types and decode helpers for the motor / led
// command deframer. No dependencies; used by the core and the testbench.
package mld_pkg;

  // frame store geometry
  localparam int FRAME_BYTES = 16;
  localparam int POS_W       = $clog2(FRAME_BYTES + 1);

  // frame positions that the decode looks at
  localparam int DEC_N = 7;
  localparam int IDX_CMD   = 0;
  localparam int IDX_DIR_L = 1;
  localparam int IDX_DIR_R = 2;
  localparam int IDX_DL_HI = 3;
  localparam int IDX_DL_LO = 4;
  localparam int IDX_DR_HI = 5;
  localparam int IDX_DR_LO = 6;

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_OPEN  = 8'h3A;
  localparam logic [7:0] CH_CLOSE = 8'h3B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_FOUR  = 8'h34;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // frame kind codes
  localparam logic [1:0] KIND_MOTOR = 2'd0;
  localparam logic [1:0] KIND_LED   = 2'd1;
  localparam logic [1:0] KIND_OTHER = 2'd2;

  // led pins after reset: back on, front off
  localparam logic [5:0] LED_RESET = 6'h30;

  // one result transaction
  typedef struct packed {
    logic [1:0] frame_kind;
    logic       left_fwd;
    logic       left_rev;
    logic       right_fwd;
    logic       right_rev;
    logic [6:0] pwm_left;
    logic [6:0] pwm_right;
    logic [3:0] front_leds;
    logic [1:0] back_leds;
  } res_t;

  // direction decode: {update, rev, fwd}
  typedef struct packed {
    logic       upd;
    logic [1:0] pins;
  } dir_t;

  // frame position held in each decode slot
  function automatic logic [POS_W-1:0] dec_pos(input int idx);
    logic [POS_W-1:0] p;
    case (idx)
      IDX_CMD:   p = POS_W'(1);
      IDX_DIR_L: p = POS_W'(3);
      IDX_DIR_R: p = POS_W'(5);
      IDX_DL_HI: p = POS_W'(7);
      IDX_DL_LO: p = POS_W'(8);
      IDX_DR_HI: p = POS_W'(10);
      IDX_DR_LO: p = POS_W'(11);
      default:   p = '0;
    endcase
    return p;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // two decimal digits, a non-digit ends the number
  function automatic logic [6:0] two_digit(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] dh;
    logic [7:0] dl;
    logic [6:0] v;
    dh = hi - CH_ZERO;
    dl = lo - CH_ZERO;
    v  = 7'd0;
    if (is_digit(hi)) begin
      v = dh[6:0];
      if (is_digit(lo)) begin
        v = (dh[6:0] << 3) + (dh[6:0] << 1) + dl[6:0];
      end
    end
    return v;
  endfunction

  function automatic dir_t dir_decode(input logic [7:0] c);
    dir_t d;
    d = '{upd: 1'b1, pins: 2'b00};
    unique case (c)
      CH_ONE:  d.pins = 2'b01;
      CH_ZERO: d.pins = 2'b10;
      CH_TWO:  d.pins = 2'b00;
      default: d.upd  = 1'b0;
    endcase
    return d;
  endfunction

  // led level digit to {back, front}
  function automatic logic [5:0] led_decode(input logic [7:0] c);
    logic [7:0] lvl;
    logic [3:0] front;
    logic [1:0] back;
    lvl   = c - CH_ZERO;
    front = 4'((5'd1 << lvl[2:0]) - 5'd1);
    back  = (lvl[2:0] != 3'd0) ? 2'b11 : 2'b00;
    return {back, front};
  endfunction

endpackage

// File: design/mld_ifs.sv
// mld_ifs: valid/ready channels for received bytes and decoded results.
// No dependencies; all widths are fixed here.
interface mld_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mld_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] frame_kind;
  logic       left_fwd;
  logic       left_rev;
  logic       right_fwd;
  logic       right_rev;
  logic [6:0] pwm_left;
  logic [6:0] pwm_right;
  logic [3:0] front_leds;
  logic [1:0] back_leds;
  modport source (output valid, output frame_kind, output left_fwd, output left_rev,
                  output right_fwd, output right_rev, output pwm_left,
                  output pwm_right, output front_leds, output back_leds,
                  input ready);
  modport sink   (input valid, input frame_kind, input left_fwd, input left_rev,
                  input right_fwd, input right_rev, input pwm_left,
                  input pwm_right, input front_leds, input back_leds,
                  output ready);
endinterface

// File: design/motor_led_command_deframer_core.sv
// motor_led_command_deframer_core: frames received bytes and decodes motor
// and led commands. Depends on mld_pkg and the channels in mld_ifs.
//
//  channel  | dir | payload                               | transaction
//  ---------+-----+---------------------------------------+--------------------
//  in_rx    | in  | rx_byte                               | one received byte
//  out_res  | out | kind, motor pins, duties, leds        | one per ';' byte
//
// One byte is taken every cycle unless the input stalls; a ';' passes the
// input register and is decoded combinationally into the result register.
// Reset (rst_n low, synchronous) closes any frame, clears the frame store,
// motor pins and duties, and lights the back leds only.
// A waiting result stalls the input only when the byte in the input register
// is another ';'; all other bytes keep flowing.
module motor_led_command_deframer_core (
  input  logic            clk,
  input  logic            rst_n,
  mld_byte_if.sink        in_rx,
  mld_res_if.source       out_res
);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       adv;
  logic       s1_close;

  // deframer state
  logic                    in_frame_r, in_frame_nxt;
  logic [mld_pkg::POS_W-1:0] wpos_r, wpos_nxt;
  logic [7:0]              dec_r   [mld_pkg::DEC_N];
  logic [7:0]              dec_nxt [mld_pkg::DEC_N];
  logic [7:0]              eff     [mld_pkg::DEC_N];
  logic [3:0]              dir_r, dir_nxt;
  logic [6:0]              duty_l_r, duty_l_nxt;
  logic [6:0]              duty_rt_r, duty_rt_nxt;
  logic [5:0]              led_r, led_nxt;
  logic [1:0]              kind;
  logic                    do_store;
  logic                    open_now;
  mld_pkg::dir_t           dl, dr;

  // result register
  logic          out_valid_r;
  mld_pkg::res_t res_r, res_nxt;

  assign s1_close    = (s1_byte_r == mld_pkg::CH_CLOSE);
  assign adv         = s1_valid_r && (!out_valid_r || out_res.ready || !s1_close);
  assign in_rx.ready = !s1_valid_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_rx.ready) begin
      s1_valid_r <= in_rx.valid;
    end
    if (in_rx.ready && in_rx.valid) begin
      s1_byte_r <= in_rx.rx_byte;
    end
  end

  // store decision and view of the frame with the current byte written in
  assign open_now = in_frame_r || (s1_byte_r == mld_pkg::CH_OPEN);
  assign do_store = adv && (s1_byte_r != mld_pkg::CH_NUL) && (open_now || s1_close)
                    && (wpos_r < mld_pkg::POS_W'(mld_pkg::FRAME_BYTES));

  always_comb begin
    for (int i = 0; i < mld_pkg::DEC_N; i++) begin
      eff[i] = (do_store && (wpos_r == mld_pkg::dec_pos(i)))
               ? s1_byte_r : dec_r[i];
    end
  end

  assign dl = mld_pkg::dir_decode(eff[mld_pkg::IDX_DIR_L]);
  assign dr = mld_pkg::dir_decode(eff[mld_pkg::IDX_DIR_R]);

  // next state and decode
  always_comb begin
    in_frame_nxt = in_frame_r;
    wpos_nxt     = wpos_r;
    dec_nxt      = dec_r;
    dir_nxt      = dir_r;
    duty_l_nxt   = duty_l_r;
    duty_rt_nxt  = duty_rt_r;
    led_nxt      = led_r;
    kind         = mld_pkg::KIND_OTHER;

    if (adv && (s1_byte_r != mld_pkg::CH_NUL)) begin
      if (s1_byte_r == mld_pkg::CH_OPEN) begin
        in_frame_nxt = 1'b1;
      end
      if (do_store) begin
        wpos_nxt = wpos_r + mld_pkg::POS_W'(1);
        dec_nxt  = eff;
      end
      if (s1_close) begin
        // decode the closed frame, then empty the store
        if (eff[mld_pkg::IDX_CMD] == mld_pkg::CH_ZERO) begin
          kind = mld_pkg::KIND_MOTOR;
          if (dl.upd) dir_nxt[1:0] = dl.pins;
          if (dr.upd) dir_nxt[3:2] = dr.pins;
          duty_l_nxt  = mld_pkg::two_digit(eff[mld_pkg::IDX_DL_HI], eff[mld_pkg::IDX_DL_LO]);
          duty_rt_nxt = mld_pkg::two_digit(eff[mld_pkg::IDX_DR_HI], eff[mld_pkg::IDX_DR_LO]);
        end else if (eff[mld_pkg::IDX_CMD] == mld_pkg::CH_ONE) begin
          kind = mld_pkg::KIND_LED;
          if ((eff[mld_pkg::IDX_DIR_L] >= mld_pkg::CH_ZERO) &&
              (eff[mld_pkg::IDX_DIR_L] <= mld_pkg::CH_FOUR)) begin
            led_nxt = mld_pkg::led_decode(eff[mld_pkg::IDX_DIR_L]);
          end
        end
        in_frame_nxt = 1'b0;
        wpos_nxt     = '0;
        for (int i = 0; i < mld_pkg::DEC_N; i++) begin
          dec_nxt[i] = 8'h00;
        end
      end
    end

    res_nxt.frame_kind = kind;
    res_nxt.left_fwd   = dir_nxt[0];
    res_nxt.left_rev   = dir_nxt[1];
    res_nxt.right_fwd  = dir_nxt[2];
    res_nxt.right_rev  = dir_nxt[3];
    res_nxt.pwm_left   = duty_l_nxt;
    res_nxt.pwm_right  = duty_rt_nxt;
    res_nxt.front_leds = led_nxt[3:0];
    res_nxt.back_leds  = led_nxt[5:4];
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      wpos_r     <= '0;
      dir_r      <= 4'h0;
      duty_l_r   <= 7'd0;
      duty_rt_r  <= 7'd0;
      led_r      <= mld_pkg::LED_RESET;
      for (int i = 0; i < mld_pkg::DEC_N; i++) begin
        dec_r[i] <= 8'h00;
      end
    end else begin
      in_frame_r <= in_frame_nxt;
      wpos_r     <= wpos_nxt;
      dir_r      <= dir_nxt;
      duty_l_r   <= duty_l_nxt;
      duty_rt_r  <= duty_rt_nxt;
      led_r      <= led_nxt;
      dec_r      <= dec_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (out_valid_r && !out_res.ready) || (adv && s1_close);
    end
    if (adv && s1_close) begin
      res_r <= res_nxt;
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.frame_kind = res_r.frame_kind;
  assign out_res.left_fwd   = res_r.left_fwd;
  assign out_res.left_rev   = res_r.left_rev;
  assign out_res.right_fwd  = res_r.right_fwd;
  assign out_res.right_rev  = res_r.right_rev;
  assign out_res.pwm_left   = res_r.pwm_left;
  assign out_res.pwm_right  = res_r.pwm_right;
  assign out_res.front_leds = res_r.front_leds;
  assign out_res.back_leds  = res_r.back_leds;

  // checks
  a_wpos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wpos_r <= mld_pkg::POS_W'(mld_pkg::FRAME_BYTES))
    else $error("write position past frame end");

  a_close_result: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_close) |=> out_valid_r)
    else $error("closed frame gave no result");

  a_close_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_close) |=> (wpos_r == '0 && !in_frame_r))
    else $error("frame not emptied after close");

  a_back_pair: assert property (@(posedge clk) disable iff (!rst_n)
    led_r[5] == led_r[4])
    else $error("back leds out of step");

endmodule

// File: tb/sv/motor_led_command_deframer_core_tb.sv
// motor_led_command_deframer_core_tb: self-checking bench for the command deframer,
// with byte stimulus, random idling on both channels and a frame decode scoreboard.
// Depends on mld_pkg, the channels in mld_ifs and motor_led_command_deframer_core.
module motor_led_command_deframer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_BYTES      = 1750;
  localparam int CALM_TAIL    = 150;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  // tracks frame assembly and pin state, holds the status words still to come
  class status_scoreboard;
    bit               open;
    int unsigned      wpos;
    logic [7:0]       fstore [mld_pkg::FRAME_BYTES];
    logic [3:0]       dir;
    logic [6:0]       duty_l;
    logic [6:0]       duty_r;
    logic [5:0]       leds;
    mld_pkg::res_t    pending_status [$];
    int               errors;

    function new();
      open   = 1'b0;
      dir    = '0;
      duty_l = '0;
      duty_r = '0;
      leds   = mld_pkg::LED_RESET;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      foreach (fstore[i]) fstore[i] = '0;
      wpos = 0;
    endfunction

    // saturating store, bytes past the end are dropped
    function void keep(logic [7:0] b);
      if (wpos < mld_pkg::FRAME_BYTES) begin
        fstore[wpos] = b;
        wpos++;
      end
    endfunction

    function bit is_num(logic [7:0] c);
      return (c >= mld_pkg::CH_ZERO) && (c <= mld_pkg::CH_NINE);
    endfunction

    // one motor's pins {rev, fwd}, unknown digit keeps them
    function logic [1:0] steer(logic [7:0] c, logic [1:0] cur);
      case (c)
        mld_pkg::CH_ONE:  return 2'b01;
        mld_pkg::CH_ZERO: return 2'b10;
        mld_pkg::CH_TWO:  return 2'b00;
        default:          return cur;
      endcase
    endfunction

    // up to two decimal digits, a non-digit ends the number
    function logic [6:0] duty_of(logic [7:0] hi, logic [7:0] lo);
      int v;
      if (!is_num(hi)) return 7'd0;
      v = hi - mld_pkg::CH_ZERO;
      if (is_num(lo)) v = v * 10 + (lo - mld_pkg::CH_ZERO);
      return 7'(v);
    endfunction

    // note one accepted byte, predicting the status word on a close
    function void take_byte(logic [7:0] b);
      mld_pkg::res_t r;
      int            lvl;
      if (b == mld_pkg::CH_NUL) return;
      if (b == mld_pkg::CH_OPEN) open = 1'b1;
      if (b != mld_pkg::CH_CLOSE) begin
        if (open) keep(b);
        return;
      end
      open = 1'b0;
      keep(b);
      r = '0;
      if (fstore[1] == mld_pkg::CH_ZERO) begin
        r.frame_kind = mld_pkg::KIND_MOTOR;
        dir[1:0] = steer(fstore[3], dir[1:0]);
        dir[3:2] = steer(fstore[5], dir[3:2]);
        duty_l   = duty_of(fstore[7], fstore[8]);
        duty_r   = duty_of(fstore[10], fstore[11]);
      end else if (fstore[1] == mld_pkg::CH_ONE) begin
        r.frame_kind = mld_pkg::KIND_LED;
        if (fstore[3] >= mld_pkg::CH_ZERO && fstore[3] <= mld_pkg::CH_FOUR) begin
          lvl       = fstore[3] - mld_pkg::CH_ZERO;
          leds[3:0] = 4'((1 << lvl) - 1);
          leds[5:4] = (lvl != 0) ? 2'b11 : 2'b00;
        end
      end else begin
        r.frame_kind = mld_pkg::KIND_OTHER;
      end
      clear_frame();
      r.left_fwd   = dir[0];
      r.left_rev   = dir[1];
      r.right_fwd  = dir[2];
      r.right_rev  = dir[3];
      r.pwm_left   = duty_l;
      r.pwm_right  = duty_r;
      r.front_leds = leds[3:0];
      r.back_leds  = leds[5:4];
      pending_status.push_back(r);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned seen);
      if (want != seen) begin
        $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, seen);
        errors++;
      end
    endfunction

    // compare one status transaction with the oldest prediction
    function void check_status(mld_pkg::res_t got);
      mld_pkg::res_t want;
      if (pending_status.size() == 0) begin
        $display("%0t unexpected status transaction: expected none, actual %h",
                 $time, got);
        errors++;
        return;
      end
      want = pending_status.pop_front();
      check_field("frame_kind", want.frame_kind, got.frame_kind);
      check_field("left_fwd",   want.left_fwd,   got.left_fwd);
      check_field("left_rev",   want.left_rev,   got.left_rev);
      check_field("right_fwd",  want.right_fwd,  got.right_fwd);
      check_field("right_rev",  want.right_rev,  got.right_rev);
      check_field("pwm_left",   want.pwm_left,   got.pwm_left);
      check_field("pwm_right",  want.pwm_right,  got.pwm_right);
      check_field("front_leds", want.front_leds, got.front_leds);
      check_field("back_leds",  want.back_leds,  got.back_leds);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  mld_byte_if in_rx ();
  mld_res_if  out_res ();

  status_scoreboard sb = new();
  logic [7:0]       tx_bytes [$];
  bit               calm;
  int               gap_odds;
  int               cycle_cnt;

  motor_led_command_deframer_core u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_rx   (in_rx),
    .out_res (out_res)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic push_text(string s);
    for (int k = 0; k < s.len(); k++) tx_bytes.push_back(8'(s[k]));
  endtask

  // one random frame, mostly well formed, sometimes noise, short, long or unclosed
  task automatic add_random_frame();
    int         pick;
    int         last;
    int         extra;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      repeat ($urandom_range(1, 6)) tx_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    tx_bytes.push_back(mld_pkg::CH_OPEN);
    pick = $urandom_range(0, 99);
    if (pick < 45) c = mld_pkg::CH_ZERO;
    else if (pick < 85) c = mld_pkg::CH_ONE;
    else c = 8'($urandom_range(0, 255));
    tx_bytes.push_back(c);
    // short frames stop early, long ones can run past the end of the store
    last = 11;
    pick = $urandom_range(0, 99);
    if (pick < 12) last = $urandom_range(1, 10);
    extra = (pick >= 88) ? $urandom_range(1, 10) : 0;
    for (int p = 2; p <= last + extra; p++) begin
      if ($urandom_range(0, 39) == 0) tx_bytes.push_back(mld_pkg::CH_NUL);
      if ($urandom_range(0, 9) == 0) c = 8'($urandom_range(0, 255));
      else if (p == 3 || p == 5) c = 8'(mld_pkg::CH_ZERO + $urandom_range(0, 5));
      else if (p inside {7, 8, 10, 11}) c = 8'(mld_pkg::CH_ZERO + $urandom_range(0, 9));
      else c = CH_COMMA;
      tx_bytes.push_back(c);
    end
    if ($urandom_range(0, 24) != 0) tx_bytes.push_back(mld_pkg::CH_CLOSE);
  endtask

  // cycle counter guards against a hang
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // status channel back-pressure in bursts, none in the last part
  initial begin
    out_res.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (calm || $urandom_range(0, 2) != 0) begin
        out_res.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else begin
        out_res.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
    end
  end

  // status monitor
  always @(posedge clk) begin
    mld_pkg::res_t got;
    if (rst_n && out_res.valid && out_res.ready) begin
      got.frame_kind = out_res.frame_kind;
      got.left_fwd   = out_res.left_fwd;
      got.left_rev   = out_res.left_rev;
      got.right_fwd  = out_res.right_fwd;
      got.right_rev  = out_res.right_rev;
      got.pwm_left   = out_res.pwm_left;
      got.pwm_right  = out_res.pwm_right;
      got.front_leds = out_res.front_leds;
      got.back_leds  = out_res.back_leds;
      sb.check_status(got);
    end
  end

  // byte driver and run control
  initial begin
    rst_n          <= 1'b0;
    in_rx.valid    <= 1'b0;
    in_rx.rx_byte  <= '0;
    calm            = 1'b0;
    gap_odds        = 4;

    // directed: zero byte, stray byte, close with no open, colon inside a frame,
    // led levels at both ends and an invalid level digit
    tx_bytes.push_back(mld_pkg::CH_NUL);
    tx_bytes.push_back(8'hFF);
    tx_bytes.push_back(mld_pkg::CH_CLOSE);
    push_text(":0,1:0,99,00;");
    push_text(":1,4;");
    push_text(":1,7;");
    push_text(":1,0;");
    while (tx_bytes.size() < N_BYTES) add_random_frame();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < tx_bytes.size(); i++) begin
      if (i >= tx_bytes.size() - CALM_TAIL) calm = 1'b1;
      // vary the gap density, zero gives a stretch with no idling
      if (i % 200 == 0) gap_odds = $urandom_range(0, 1) ? 0 : $urandom_range(2, 10);
      if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
        in_rx.valid <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      in_rx.valid   <= 1'b1;
      in_rx.rx_byte <= tx_bytes[i];
      @(posedge clk);
      while (!in_rx.ready) @(posedge clk);
      sb.take_byte(tx_bytes[i]);
    end
    in_rx.valid <= 1'b0;

    // drain, then keep watching for anything unexpected
    while (sb.pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_status.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
design/mld_pkg.sv
design/mld_ifs.sv
design/motor_led_command_deframer_core.sv
tb/sv/motor_led_command_deframer_core_tb.sv
